[rtl/lfe_pkg.sv]
// Package for the Langermann fitness pipeline: formats, term constants,
// Horner divisors and their reciprocals. No dependencies.
package lfe_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int TERM_COUNT = 5;
  localparam int COORD_W    = 22;
  localparam int OUT_W      = 21;
  localparam int EXP_STEPS  = 11;
  localparam int COS_STEPS  = 7;

  // r below the far limit (128.0) needs 7 integer bits
  localparam int R_W   = 7 + FRAC_BITS;
  localparam int U_W   = R_W - 1;
  localparam int N_W   = U_W - FRAC_BITS;
  localparam int RND_SH = 30 - FRAC_BITS;

  localparam logic signed [32:0] Q30_ONE = 33'sd1073741824;
  localparam logic [30:0] KQ32    = 31'd1972352491;
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  localparam logic [31:0] PI_Q30  = 32'd3373259426;

  localparam int CEN_A [5] = '{3, 5, 2, 1, 7};
  localparam int CEN_B [5] = '{5, 2, 1, 4, 9};
  localparam int WGT_C [5] = '{1, 2, 5, 2, 3};

  // Horner divisors in step order, with floor(2^34 / k)
  localparam int EXP_DIV [EXP_STEPS] = '{11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 1};
  localparam logic [34:0] EXP_RCP [EXP_STEPS] = '{
    35'd1561806289, 35'd1717986918, 35'd1908874353, 35'd2147483648,
    35'd2454267026, 35'd2863311530, 35'd3435973836, 35'd4294967296,
    35'd5726623061, 35'd8589934592, 35'd17179869184};
  localparam int COS_DIV [COS_STEPS] = '{182, 132, 90, 56, 30, 12, 2};
  localparam logic [34:0] COS_RCP [COS_STEPS] = '{
    35'd94394885, 35'd130150524, 35'd190887435, 35'd306783378,
    35'd572662306, 35'd1431655765, 35'd8589934592};

  // per-term flags and exp shift count that ride alongside the Horner chains
  typedef struct packed {
    logic           far;
    logic           cneg;
    logic [N_W-1:0] n;
  } side_t;

endpackage

[rtl/langermann_fitness_eval_core.sv]
// Langermann fitness evaluator, fully pipelined top level.
// Depends on lfe_pkg.
// Throughput: one word per cycle; every multiply and Horner divide step has
// its own register stage, and exp(11 steps) sets the pipeline depth.
// Stalls hold each occupied stage; empty stages keep filling (bubble collapse).
// Reset (rst, synchronous) clears the stage valid bits only.
module langermann_fitness_eval_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  output logic                                 item_ready,
  input  logic signed [lfe_pkg::COORD_W-1:0]   x_coord,
  input  logic signed [lfe_pkg::COORD_W-1:0]   y_coord,
  output logic                                 result_valid,
  input  logic                                 result_ready,
  output logic signed [lfe_pkg::OUT_W-1:0]     fitness_value
);
  import lfe_pkg::*;

  localparam int ST_IN   = 0;
  localparam int ST_ABS  = 1;
  localparam int ST_SQ   = 2;
  localparam int ST_R    = 3;
  localparam int ST_U    = 4;
  localparam int ST_Z    = 5;
  localparam int ST_T2   = 6;
  localparam int ST_HRN  = 7;
  localparam int ST_EXP_END = ST_HRN + 3 * EXP_STEPS - 1;
  localparam int ST_COS_END = ST_HRN + 3 * COS_STEPS - 1;
  localparam int ST_EC   = ST_EXP_END + 1;
  localparam int ST_PROD = ST_EC + 1;
  localparam int ST_WGT  = ST_PROD + 1;
  localparam int ST_SUM  = ST_WGT + 1;
  localparam int ST_OUT  = ST_SUM + 1;
  localparam int NS      = ST_OUT + 1;
  localparam int CDLY    = ST_EXP_END - ST_COS_END;
  localparam int SIDE_N  = ST_EXP_END - ST_Z + 1;

  localparam int DW   = COORD_W + 1;
  localparam int SQ_W = 2 * COORD_W;
  localparam int WW   = FRAC_BITS + 2;
  localparam int SUM_W = 40;
  localparam logic [WW-1:0] ONE_F  = WW'(1) << FRAC_BITS;
  localparam logic [WW-1:0] TWO_F  = WW'(1) << (FRAC_BITS + 1);
  localparam logic [WW-1:0] HALF_F = WW'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0] RND_HALF = SUM_W'(1) << (RND_SH - 1);
  localparam logic [SUM_W-1:0] OUT_POS  = SUM_W'((1 << (OUT_W - 1)) - 1);
  localparam logic [SUM_W-1:0] OUT_NEG  = SUM_W'(1 << (OUT_W - 1));

  // ---------------- stage valid / enable chain ----------------
  logic [NS-1:0] vld, en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || result_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= item_valid;
      for (int i = 1; i < NS; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign item_ready   = en[ST_IN];
  assign result_valid = vld[NS-1];

  // ---------------- input register ----------------
  // The signed 22-bit coordinate spans -32 to just under +32, so saturation is a no-op.
  logic signed [COORD_W-1:0] xs, ys;

  always_ff @(posedge clk) begin
    if (en[ST_IN]) begin
      xs <= x_coord;
      ys <= y_coord;
    end
  end

  // ---------------- per-term registers ----------------
  logic [COORD_W-1:0]   ax    [TERM_COUNT];
  logic [COORD_W-1:0]   ay    [TERM_COUNT];
  logic [SQ_W-1:0]      sqx   [TERM_COUNT];
  logic [SQ_W-1:0]      sqy   [TERM_COUNT];
  logic [R_W-1:0]       r3    [TERM_COUNT];
  logic                 far3  [TERM_COUNT];
  logic [U_W-1:0]       u4    [TERM_COUNT];
  logic                 far4  [TERM_COUNT];
  logic                 cneg4 [TERM_COUNT];
  logic [FRAC_BITS-1:0] w4    [TERM_COUNT];
  logic [29:0]          z5    [TERM_COUNT];
  logic [30:0]          th5   [TERM_COUNT];
  logic [29:0]          z6    [TERM_COUNT];
  logic [31:0]          t2_6  [TERM_COUNT];
  side_t                side  [TERM_COUNT][SIDE_N];

  logic [31:0]        e_aop  [TERM_COUNT][EXP_STEPS];
  logic [63:0]        e_apr  [TERM_COUNT][EXP_STEPS];
  logic               e_aneg [TERM_COUNT][EXP_STEPS];
  logic [31:0]        e_bop  [TERM_COUNT][EXP_STEPS];
  logic [32:0]        e_bm   [TERM_COUNT][EXP_STEPS];
  logic [67:0]        e_bmm  [TERM_COUNT][EXP_STEPS];
  logic               e_bneg [TERM_COUNT][EXP_STEPS];
  logic [31:0]        e_cop  [TERM_COUNT][EXP_STEPS];
  logic signed [32:0] e_cp   [TERM_COUNT][EXP_STEPS];

  logic [31:0]        c_aop  [TERM_COUNT][COS_STEPS];
  logic [63:0]        c_apr  [TERM_COUNT][COS_STEPS];
  logic               c_aneg [TERM_COUNT][COS_STEPS];
  logic [31:0]        c_bop  [TERM_COUNT][COS_STEPS];
  logic [32:0]        c_bm   [TERM_COUNT][COS_STEPS];
  logic [67:0]        c_bmm  [TERM_COUNT][COS_STEPS];
  logic               c_bneg [TERM_COUNT][COS_STEPS];
  logic [31:0]        c_cop  [TERM_COUNT][COS_STEPS];
  logic signed [32:0] c_cp   [TERM_COUNT][COS_STEPS];

  logic signed [32:0] cd     [TERM_COUNT][CDLY];
  logic [30:0]        e40    [TERM_COUNT];
  logic signed [32:0] c40    [TERM_COUNT];
  logic [62:0]        pr41   [TERM_COUNT];
  logic               neg41  [TERM_COUNT];
  logic signed [36:0] w42    [TERM_COUNT];

  for (genvar l = 0; l < TERM_COUNT; l++) begin : g_term
    logic signed [DW-1:0] dx, dy;
    logic [SQ_W:0]        sq_sum;
    logic [R_W+31-1:0]    ukq;
    logic [WW-1:0]        wr, wa, wb;
    logic                 wneg;
    logic [59:0]          zp;
    logic [61:0]          thp;
    logic [61:0]          t2p;
    logic [31:0]          cmag;
    logic [32:0]          m42;
    logic signed [33:0]   ts42;
    logic signed [32:0]   pe;
    side_t                sd;

    assign dx = DW'(xs) - (DW'(CEN_A[l]) <<< FRAC_BITS);
    assign dy = DW'(ys) - (DW'(CEN_B[l]) <<< FRAC_BITS);
    assign sq_sum = (SQ_W + 1)'(sqx[l]) + (SQ_W + 1)'(sqy[l]);
    assign ukq = r3[l] * KQ32;

    // fold r mod 2 into [0, 1/2] (up to a quarter turn) with a sign
    assign wr   = WW'(r3[l][FRAC_BITS:0]);
    assign wa   = (wr > ONE_F) ? (TWO_F - wr) : wr;
    assign wneg = (wa > HALF_F);
    assign wb   = wneg ? (ONE_F - wa) : wa;

    assign zp  = {u4[l][FRAC_BITS-1:0], (30 - FRAC_BITS)'(0)} * LN2_Q30;
    assign thp = {w4[l], (30 - FRAC_BITS)'(0)} * PI_Q30;
    assign t2p = th5[l] * th5[l];

    always_ff @(posedge clk) begin
      if (en[ST_ABS]) begin
        ax[l] <= dx[DW-1] ? COORD_W'(-dx) : COORD_W'(dx);
        ay[l] <= dy[DW-1] ? COORD_W'(-dy) : COORD_W'(dy);
      end
      if (en[ST_SQ]) begin
        sqx[l] <= ax[l] * ax[l];
        sqy[l] <= ay[l] * ay[l];
      end
      if (en[ST_R]) begin
        r3[l]   <= sq_sum[FRAC_BITS +: R_W];
        far3[l] <= |sq_sum[SQ_W:FRAC_BITS+R_W];
      end
      if (en[ST_U]) begin
        u4[l]    <= ukq[32 +: U_W];
        far4[l]  <= far3[l];
        cneg4[l] <= wneg;
        w4[l]    <= wb[FRAC_BITS-1:0];
      end
      if (en[ST_Z]) begin
        z5[l]        <= zp[30 +: 30];
        th5[l]       <= thp[30 +: 31];
        side[l][0]   <= '{far: far4[l], cneg: cneg4[l], n: u4[l][U_W-1:FRAC_BITS]};
      end
      if (en[ST_T2]) begin
        z6[l]   <= z5[l];
        t2_6[l] <= t2p[30 +: 32];
      end
      for (int s = 1; s < SIDE_N; s++) begin
        if (en[ST_Z + s]) side[l][s] <= side[l][s-1];
      end
    end

    // ---- exp(-z) Horner chain: p = 1 - z*p/k, three stages a step ----
    for (genvar j = 0; j < EXP_STEPS; j++) begin : g_exp
      localparam int SA = ST_HRN + 3 * j;
      logic [31:0]        op_in;
      logic signed [32:0] p_in;
      logic [31:0]        pm;
      logic [32:0]        q0, rem, q;
      logic [32:0]        kk;

      if (j == 0) begin : g_first
        assign op_in = 32'(z6[l]);
        assign p_in  = Q30_ONE;
      end else begin : g_next
        assign op_in = e_cop[l][j-1];
        assign p_in  = e_cp[l][j-1];
      end

      assign pm  = p_in[32] ? 32'(-p_in) : 32'(p_in);
      assign kk  = 33'(EXP_DIV[j]);
      assign q0  = e_bmm[l][j][34 +: 33];
      assign rem = e_bm[l][j] - q0 * kk;
      assign q   = (rem >= kk) ? q0 + 33'd1 : q0;

      always_ff @(posedge clk) begin
        if (en[SA]) begin
          e_aop[l][j]  <= op_in;
          e_apr[l][j]  <= op_in * pm;
          e_aneg[l][j] <= p_in[32];
        end
        if (en[SA + 1]) begin
          e_bop[l][j]  <= e_aop[l][j];
          e_bm[l][j]   <= e_apr[l][j][30 +: 33];
          e_bmm[l][j]  <= e_apr[l][j][30 +: 33] * EXP_RCP[j];
          e_bneg[l][j] <= e_aneg[l][j];
        end
        if (en[SA + 2]) begin
          e_cop[l][j] <= e_bop[l][j];
          e_cp[l][j]  <= e_bneg[l][j] ? Q30_ONE + $signed(q) : Q30_ONE - $signed(q);
        end
      end
    end

    // ---- cos Horner chain over theta^2 ----
    for (genvar j = 0; j < COS_STEPS; j++) begin : g_cos
      localparam int SA = ST_HRN + 3 * j;
      logic [31:0]        op_in;
      logic signed [32:0] p_in;
      logic [31:0]        pm;
      logic [32:0]        q0, rem, q;
      logic [32:0]        kk;

      if (j == 0) begin : g_first
        assign op_in = t2_6[l];
        assign p_in  = Q30_ONE;
      end else begin : g_next
        assign op_in = c_cop[l][j-1];
        assign p_in  = c_cp[l][j-1];
      end

      assign pm  = p_in[32] ? 32'(-p_in) : 32'(p_in);
      assign kk  = 33'(COS_DIV[j]);
      assign q0  = c_bmm[l][j][34 +: 33];
      assign rem = c_bm[l][j] - q0 * kk;
      assign q   = (rem >= kk) ? q0 + 33'd1 : q0;

      always_ff @(posedge clk) begin
        if (en[SA]) begin
          c_aop[l][j]  <= op_in;
          c_apr[l][j]  <= op_in * pm;
          c_aneg[l][j] <= p_in[32];
        end
        if (en[SA + 1]) begin
          c_bop[l][j]  <= c_aop[l][j];
          c_bm[l][j]   <= c_apr[l][j][30 +: 33];
          c_bmm[l][j]  <= c_apr[l][j][30 +: 33] * COS_RCP[j];
          c_bneg[l][j] <= c_aneg[l][j];
        end
        if (en[SA + 2]) begin
          c_cop[l][j] <= c_bop[l][j];
          c_cp[l][j]  <= c_bneg[l][j] ? Q30_ONE + $signed(q) : Q30_ONE - $signed(q);
        end
      end
    end

    // ---- combine exp and cos, weight ----
    assign pe   = e_cp[l][EXP_STEPS-1];
    assign sd   = side[l][SIDE_N-1];
    assign cmag = c40[l][32] ? 32'(-c40[l]) : 32'(c40[l]);
    assign m42  = pr41[l][30 +: 33];
    assign ts42 = neg41[l] ? -$signed({1'b0, m42}) : $signed({1'b0, m42});

    always_ff @(posedge clk) begin
      if (en[ST_COS_END + 1]) cd[l][0] <= c_cp[l][COS_STEPS-1];
      for (int i = 1; i < CDLY; i++) begin
        if (en[ST_COS_END + 1 + i]) cd[l][i] <= cd[l][i-1];
      end
      if (en[ST_EC]) begin
        // far term or non-positive exp series gives zero
        e40[l] <= (sd.far || pe[32] || pe == '0) ? '0 : (31'(pe) >> sd.n);
        c40[l] <= sd.cneg ? -cd[l][CDLY-1] : cd[l][CDLY-1];
      end
      if (en[ST_PROD]) begin
        pr41[l]  <= e40[l] * cmag;
        neg41[l] <= c40[l][32];
      end
      if (en[ST_WGT]) begin
        w42[l] <= 37'(ts42) * 37'(WGT_C[l]);
      end
    end
  end

  // ---------------- sum, round, saturate ----------------
  logic signed [SUM_W-1:0] acc, sum43;
  logic [SUM_W-1:0]        mag, rnd;

  always_comb begin
    acc = '0;
    for (int l = 0; l < TERM_COUNT; l++) begin
      acc = acc + SUM_W'(w42[l]);
    end
  end

  assign mag = sum43[SUM_W-1] ? SUM_W'(-sum43) : SUM_W'(sum43);
  assign rnd = (mag + RND_HALF) >> RND_SH;

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) sum43 <= acc;
    if (en[ST_OUT]) begin
      if (sum43[SUM_W-1]) begin
        fitness_value <= (rnd > OUT_NEG) ? -OUT_W'(OUT_NEG) : -OUT_W'(rnd);
      end else begin
        fitness_value <= (rnd > OUT_POS) ? OUT_W'(OUT_POS) : OUT_W'(rnd);
      end
    end
  end

endmodule

[verif/lfe_checker.sv]
// Checker for the Langermann fitness core: watches both channels, predicts
// the fitness of each accepted point and compares it. Depends on lfe_pkg.
`timescale 1ns / 1ps
module lfe_checker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 item_valid,
  input  logic                                 item_ready,
  input  logic signed [lfe_pkg::COORD_W-1:0]   x_coord,
  input  logic signed [lfe_pkg::COORD_W-1:0]   y_coord,
  input  logic                                 result_valid,
  input  logic                                 result_ready,
  input  logic signed [lfe_pkg::OUT_W-1:0]     fitness_value,
  output int                                   fail_count,
  output int                                   pending_count
);
  import lfe_pkg::*;

  logic signed [OUT_W-1:0] fitness_q[$];

  // Q30 product, magnitude truncated toward zero
  function automatic longint q30_mul(longint a, longint b);
    logic [63:0] ma, mb, m;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    m = (ma * mb) >> 30;
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(32) << FRAC_BITS) - 1;
    lo = -(longint'(32) << FRAC_BITS);
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic longint decay_q30(logic [63:0] r);
    logic [63:0] u, n, f;
    longint z, p;
    u = (r * 64'd1972352491) >> 32;
    n = u >> FRAC_BITS;
    f = u & ((64'd1 << FRAC_BITS) - 1);
    z = longint'(((f << (30 - FRAC_BITS)) * 64'd744261118) >> 30);
    p = longint'(1) << 30;
    for (int k = 11; k >= 1; k--) p = (longint'(1) << 30) - q30_mul(z, p) / k;
    if (n >= 62 || p <= 0) return 0;
    return longint'(64'(p) >> n);
  endfunction

  function automatic longint wave_q30(logic [63:0] r);
    logic [63:0] one, w;
    logic neg;
    longint th, t2, p;
    one = 64'd1 << FRAC_BITS;
    w = r & ((one << 1) - 1);
    neg = 0;
    if (w > one) w = (one << 1) - w;
    if (w > (one >> 1)) begin
      w = one - w;
      neg = 1;
    end
    th = longint'(((w << (30 - FRAC_BITS)) * 64'd3373259426) >> 30);
    t2 = q30_mul(th, th);
    p = longint'(1) << 30;
    for (int k = 7; k >= 1; k--)
      p = (longint'(1) << 30) - q30_mul(t2, p) / ((2 * k - 1) * (2 * k));
    return neg ? -p : p;
  endfunction

  function automatic logic signed [OUT_W-1:0] langermann_fitness(
      logic signed [COORD_W-1:0] xi, logic signed [COORD_W-1:0] yi);
    longint x, y, dx, dy, sum, res;
    logic [63:0] ax, ay, r, mag;
    x = clamp_coord(longint'(xi));
    y = clamp_coord(longint'(yi));
    sum = 0;
    for (int i = 0; i < TERM_COUNT; i++) begin
      dx = x - (longint'(CEN_A[i]) << FRAC_BITS);
      dy = y - (longint'(CEN_B[i]) << FRAC_BITS);
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      r = (ax * ax + ay * ay) >> FRAC_BITS;
      if (r < (64'd128 << FRAC_BITS))
        sum += WGT_C[i] * q30_mul(decay_q30(r), wave_q30(r));
    end
    mag = sum < 0 ? -sum : sum;
    mag = (mag + (64'd1 << (RND_SH - 1))) >> RND_SH;
    if (mag > (64'd1 << 21)) mag = 64'd1 << 21;
    res = sum < 0 ? -longint'(mag) : longint'(mag);
    if (res > 1048575) res = 1048575;
    if (res < -1048576) res = -1048576;
    return res[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending_count = fitness_q.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready)
        fitness_q.push_back(langermann_fitness(x_coord, y_coord));
      if (result_valid && result_ready) begin
        if (fitness_q.size() == 0)
          report_mismatch("result word with nothing expected");
        else if (fitness_value !== fitness_q[0]) begin
          report_mismatch($sformatf("fitness_value got %0d want %0d",
                                    fitness_value, fitness_q[0]));
          void'(fitness_q.pop_front());
        end else
          void'(fitness_q.pop_front());
      end
    end
  end
endmodule

[verif/testbench.sv]
// Top of the Langermann fitness core testbench: clock, reset, point stimulus
// and sink stalls. Depends on lfe_pkg, langermann_fitness_eval_core, lfe_checker.
`timescale 1ns / 1ps
module testbench;
  import lfe_pkg::*;

  logic clk, rst;
  logic item_valid, item_ready, result_valid, result_ready;
  logic signed [COORD_W-1:0] x_coord, y_coord;
  logic signed [OUT_W-1:0] fitness_value;
  int fail_count, pending_count;
  int idle_pct;       // sender gap percentage
  int sink_idle_pct;  // receiver stall percentage
  int sink_hold;      // forced receiver hold-off, in cycles

  langermann_fitness_eval_core uut (.*);
  lfe_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** langermann_fitness_eval_core: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      result_ready <= 0;
    end else
      result_ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // whole-number coordinate, wrapped to the port width
  function automatic logic signed [COORD_W-1:0] to_coord(int v);
    return COORD_W'(v <<< FRAC_BITS);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(5))
      0: return COORD_W'($urandom);                                // any bit pattern
      1: return COORD_W'($urandom_range(2 << FRAC_BITS)
                + ($urandom_range(9) << FRAC_BITS) - (2 << FRAC_BITS)); // near centres
      default: return COORD_W'($urandom_range(24 << FRAC_BITS) - (8 << FRAC_BITS));
    endcase
  endfunction

  task automatic send_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 0;
      @(posedge clk);
    end
    item_valid <= 1;
    x_coord <= x;
    y_coord <= y;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  task automatic drain();
    item_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic signed [COORD_W-1:0] xs[8];
    rst = 1;
    item_valid = 0;
    x_coord = 0;
    y_coord = 0;
    result_ready = 0;
    sink_hold = 0;
    idle_pct = 0;
    sink_idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    // corners, saturation, exact centres, far terms
    xs = '{22'sh1FFFFF, -22'sh200000, 22'sh0, 22'sh1FFFFF >>> 0, to_coord(3),
           -22'sh1, to_coord(7), COORD_W'(1 << (FRAC_BITS - 1))};
    for (int i = 0; i < 8; i++) send_point(xs[i], xs[(i * 3 + 1) % 8]);
    send_point(to_coord(3), to_coord(5));
    send_point(to_coord(5), to_coord(2));
    send_point(to_coord(2), to_coord(1));
    send_point(to_coord(1), to_coord(4));
    send_point(to_coord(7), to_coord(9));
    send_point(to_coord(32), to_coord(-32));
    send_point(22'sh155555, -22'sh155556);
    send_point(-22'sh0AAAAB, 22'sh0AAAAA);
    // receiver held off while points keep coming: pipeline fills and stalls
    sink_hold <= 150;
    for (int i = 0; i < 80; i++) send_point(rand_coord(), rand_coord());
    drain();
    idle_pct = 15;
    sink_idle_pct = 15;
    for (int i = 0; i < 360; i++) begin
      if (i == 150) begin
        idle_pct = 0;
        sink_idle_pct = 0;
      end
      if (i == 230) begin
        idle_pct = 15;
        sink_idle_pct = 15;
        drain();
      end
      send_point(rand_coord(), rand_coord());
    end
    drain();
    repeat (60) @(posedge clk);
    if (fail_count == 0)
      $display("** langermann_fitness_eval_core: PASSED **");
    else
      $display("** langermann_fitness_eval_core: FAILED **");
    $finish;
  end
endmodule
